@@ sv/vmi_pkg.sv @@
// ----------------------------------------------------------------------------
// vmi_pkg: shared constants for the vector magnitude block
// Default component width and the depth of the queue between the front
// and back parts.
// ----------------------------------------------------------------------------
`default_nettype none

package vmi_pkg;

    // Width of one signed vector component.
    localparam int COMPONENT_WIDTH = 16;

    // Number of entries in the queue that parts the front from the back.
    localparam int QUEUE_DEPTH = 2;

endpackage

`default_nettype wire

@@ sv/vmi_front.sv @@
// ----------------------------------------------------------------------------
// vmi_front: absolute values, squares and sum of squares
// Two stallable stages: the first takes the absolute values of the two
// components, the second squares them. The sum is formed on the way out.
// ----------------------------------------------------------------------------
`default_nettype none

module vmi_front #(
    parameter int COMPONENT_WIDTH = vmi_pkg::COMPONENT_WIDTH
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    output logic                                o_ready,
    input  wire logic [COMPONENT_WIDTH-1:0]     i_leg_a,
    input  wire logic [COMPONENT_WIDTH-1:0]     i_leg_b,
    output logic                                o_valid,
    input  wire logic                           i_ready,
    output logic [2*COMPONENT_WIDTH-1:0]        o_sum
);

    localparam int W  = COMPONENT_WIDTH;
    localparam int SW = 2 * COMPONENT_WIDTH - 1;

    logic           r_abs_vld;
    logic [W-1:0]   r_abs_a;
    logic [W-1:0]   r_abs_b;
    logic           r_sq_vld;
    logic [SW-1:0]  r_sq_a;
    logic [SW-1:0]  r_sq_b;

    logic           w_en_abs;
    logic           w_en_sq;
    logic [W-1:0]   n_abs_a;
    logic [W-1:0]   n_abs_b;
    logic [2*W-1:0] w_prod_a;
    logic [2*W-1:0] w_prod_b;

    // The most negative value maps to 2^(W-1), which still fits in W bits.
    assign n_abs_a = i_leg_a[W-1] ? (~i_leg_a + 1'b1) : i_leg_a;
    assign n_abs_b = i_leg_b[W-1] ? (~i_leg_b + 1'b1) : i_leg_b;

    assign w_prod_a = r_abs_a * r_abs_a;
    assign w_prod_b = r_abs_b * r_abs_b;

    assign w_en_sq  = !r_sq_vld || i_ready;
    assign w_en_abs = !r_abs_vld || w_en_sq;
    assign o_ready  = w_en_abs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_abs_vld <= 1'b0;
            r_sq_vld  <= 1'b0;
        end else begin
            if (w_en_abs) begin
                r_abs_vld <= i_valid;
            end
            if (w_en_sq) begin
                r_sq_vld <= r_abs_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en_abs) begin
            r_abs_a <= n_abs_a;
            r_abs_b <= n_abs_b;
        end
        if (w_en_sq) begin
            r_sq_a <= w_prod_a[SW-1:0];
            r_sq_b <= w_prod_b[SW-1:0];
        end
    end

    assign o_valid = r_sq_vld;
    assign o_sum   = {1'b0, r_sq_a} + {1'b0, r_sq_b};

endmodule

`default_nettype wire

@@ sv/vmi_queue.sv @@
// ----------------------------------------------------------------------------
// vmi_queue: short register queue between front and back
// Lets the front keep taking requests while the back stalls, and the other
// way round.
// ----------------------------------------------------------------------------
`default_nettype none

module vmi_queue #(
    parameter int DATA_WIDTH = 2 * vmi_pkg::COMPONENT_WIDTH,
    parameter int DEPTH      = vmi_pkg::QUEUE_DEPTH
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_valid,
    output logic                        o_ready,
    input  wire logic [DATA_WIDTH-1:0]  i_data,
    output logic                        o_valid,
    input  wire logic                   i_ready,
    output logic [DATA_WIDTH-1:0]       o_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [DATA_WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [PW-1:0]         r_wr;
    logic [PW-1:0]         r_rd;
    logic [CW-1:0]         r_cnt;

    logic                  w_push;
    logic                  w_pop;
    logic [PW-1:0]         n_wr;
    logic [PW-1:0]         n_rd;

    assign o_ready = (r_cnt != CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];

    assign w_push = i_valid && o_ready;
    assign w_pop  = o_valid && i_ready;

    assign n_wr = (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
    assign n_rd = (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= n_wr;
            end
            if (w_pop) begin
                r_rd <= n_rd;
            end
            case ({w_push, w_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

`default_nettype wire

@@ sv/vmi_back.sv @@
// ----------------------------------------------------------------------------
// vmi_back: pipelined restoring square root
// One stage per result bit; each stage brings down two radicand bits,
// compares against the trial divisor and decides one root bit.
// ----------------------------------------------------------------------------
`default_nettype none

module vmi_back #(
    parameter int COMPONENT_WIDTH = vmi_pkg::COMPONENT_WIDTH
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    output logic                                o_ready,
    input  wire logic [2*COMPONENT_WIDTH-1:0]   i_sum,
    output logic                                o_valid,
    input  wire logic                           i_ready,
    output logic [COMPONENT_WIDTH-1:0]          o_magnitude
);

    localparam int W  = COMPONENT_WIDTH;
    localparam int DW = 2 * COMPONENT_WIDTH;
    localparam int RW = COMPONENT_WIDTH + 2;

    logic          r_vld  [0:W-1];
    logic [DW-1:0] r_rad  [0:W-1];
    logic [RW-1:0] r_rem  [0:W-1];
    logic [W-1:0]  r_root [0:W-1];

    // Index k is the input of stage k; index W is past the last stage.
    logic          w_vld  [0:W-1];
    logic [DW-1:0] w_rad  [0:W-1];
    logic [RW-1:0] w_rem  [0:W-1];
    logic [W-1:0]  w_root [0:W-1];
    logic          w_en   [0:W];

    assign w_vld[0]  = i_valid;
    assign w_rad[0]  = i_sum;
    assign w_rem[0]  = '0;
    assign w_root[0] = '0;
    assign w_en[W]   = i_ready;
    assign o_ready   = w_en[0];

    for (genvar k = 0; k < W; k++) begin : g_stage
        logic [RW+1:0] w_trial;
        logic [RW+1:0] w_cand;
        logic [RW+1:0] w_diff;
        logic          w_take;

        if (k > 0) begin : g_link
            assign w_vld[k]  = r_vld[k-1];
            assign w_rad[k]  = r_rad[k-1];
            assign w_rem[k]  = r_rem[k-1];
            assign w_root[k] = r_root[k-1];
        end

        assign w_en[k]  = !r_vld[k] || w_en[k+1];
        assign w_trial  = {w_rem[k], w_rad[k][DW-1 -: 2]};
        assign w_cand   = {2'b00, w_root[k], 2'b01};
        assign w_diff   = w_trial - w_cand;
        assign w_take   = (w_trial >= w_cand);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (w_en[k]) begin
                r_vld[k] <= w_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en[k]) begin
                r_rad[k]  <= {w_rad[k][DW-3:0], 2'b00};
                r_rem[k]  <= w_take ? w_diff[RW-1:0] : w_trial[RW-1:0];
                r_root[k] <= {w_root[k][W-2:0], w_take};
            end
        end
    end

    assign o_valid     = r_vld[W-1];
    assign o_magnitude = r_root[W-1];

endmodule

`default_nettype wire

@@ sv/vector_magnitude_isqrt.sv @@
// ----------------------------------------------------------------------------
// vector_magnitude_isqrt: floor of the length of a two-component vector
// Requests pass two front stages, the queue and one square root stage per
// result bit on their way to the result. The block takes one request per
// cycle while the output is not stalled.
// Reset is synchronous and active low; it empties the pipeline and queue.
// ----------------------------------------------------------------------------
`default_nettype none

// The front part takes a request, forms the absolute value of each
// component and squares them in a stallable two-stage pipeline. The sum of
// the squares, which needs 2*COMPONENT_WIDTH bits, enters a short queue.
// The back part drains the queue into a restoring square-root pipeline of
// COMPONENT_WIDTH stages, each of which decides one root bit with a single
// add and compare. The last stage is the output register: a finished
// result may wait there while earlier stages and the queue keep filling.
// Because the queue's ready comes from its registered fill count, a stall
// at the output does not reach the input in the same cycle.

module vector_magnitude_isqrt #(
    parameter int COMPONENT_WIDTH = vmi_pkg::COMPONENT_WIDTH,
    parameter int QUEUE_DEPTH     = vmi_pkg::QUEUE_DEPTH
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    output logic                            o_ready,
    input  wire logic [COMPONENT_WIDTH-1:0] i_leg_a,
    input  wire logic [COMPONENT_WIDTH-1:0] i_leg_b,
    output logic                            o_valid,
    input  wire logic                       i_ready,
    output logic [COMPONENT_WIDTH-1:0]      o_magnitude
);

    localparam int DW = 2 * COMPONENT_WIDTH;

    // Front to queue.
    logic          w_fq_valid;
    logic          w_fq_ready;
    logic [DW-1:0] w_fq_sum;

    // Queue to back.
    logic          w_qb_valid;
    logic          w_qb_ready;
    logic [DW-1:0] w_qb_sum;

    vmi_front #(
        .COMPONENT_WIDTH (COMPONENT_WIDTH)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_leg_a (i_leg_a),
        .i_leg_b (i_leg_b),
        .o_valid (w_fq_valid),
        .i_ready (w_fq_ready),
        .o_sum   (w_fq_sum)
    );

    // The queue holds sums of squares between the two parts.
    vmi_queue #(
        .DATA_WIDTH (DW),
        .DEPTH      (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_fq_valid),
        .o_ready (w_fq_ready),
        .i_data  (w_fq_sum),
        .o_valid (w_qb_valid),
        .i_ready (w_qb_ready),
        .o_data  (w_qb_sum)
    );

    vmi_back #(
        .COMPONENT_WIDTH (COMPONENT_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_qb_valid),
        .o_ready     (w_qb_ready),
        .i_sum       (w_qb_sum),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_magnitude (o_magnitude)
    );

endmodule

`default_nettype wire

@@ verif/tb_vector_magnitude_isqrt.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_vector_magnitude_isqrt: self-checking bench for the vector magnitude block
// Drives pairs of signed components through the request channel and compares
// every returned magnitude, in order, with a typed-in value or a local integer
// square-root predictor. A short directed table covers the zero vector, the
// full-scale and most negative components and truncation. Random requests
// follow, with random gaps on both channels and one long output stall that
// backs up the pipeline.
// ----------------------------------------------------------------------------

module tb_vector_magnitude_isqrt;

    localparam int CW              = vmi_pkg::COMPONENT_WIDTH;
    localparam int RANDOM_ITEMS    = 1450;
    localparam int BURST_ITEMS     = 80;
    localparam int BLOCK_ITEMS     = 50;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int DRAIN_CYCLES    = 40;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int NUM_DIRECTED    = 22;

    typedef logic [CW-1:0]   t_component;
    typedef logic [CW-1:0]   t_magnitude;
    typedef logic [2*CW-1:0] t_radicand;

    // One row of the directed table. Where has_value is clear the expected
    // magnitude comes from the predictor.
    typedef struct {
        t_component leg_a;
        t_component leg_b;
        bit         has_value;
        t_magnitude magnitude;
    } t_vector_row;

    // One outstanding magnitude, kept with its request for the error report.
    typedef struct {
        t_component leg_a;
        t_component leg_b;
        t_magnitude magnitude;
    } t_pending_magnitude;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       req_valid = 1'b0;
    logic       req_ready;
    t_component leg_a     = '0;
    t_component leg_b     = '0;
    logic       res_valid;
    logic       res_ready = 1'b0;
    t_magnitude magnitude;

    t_pending_magnitude magnitude_q[$];
    t_vector_row        directed_rows [NUM_DIRECTED];
    int                 error_count   = 0;
    int                 idle_cycles   = 0;

    // Handshake between the stimulus and the result sink for the long stall.
    bit hold_off_req = 1'b0;
    bit hold_active  = 1'b0;
    // Set for stretches in which neither side inserts gaps.
    bit no_idle      = 1'b0;

    always #5 clk = ~clk;

    vector_magnitude_isqrt uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_valid     (req_valid),
        .o_ready     (req_ready),
        .i_leg_a     (leg_a),
        .i_leg_b     (leg_b),
        .o_valid     (res_valid),
        .i_ready     (res_ready),
        .o_magnitude (magnitude)
    );

    // Floor of the vector length: absolute values, sum of squares, then a
    // restoring root that settles two radicand bits per step.
    function automatic t_magnitude vector_length_floor(input t_component a,
                                                       input t_component b);
        t_component mag_a;
        t_component mag_b;
        t_radicand  radicand;
        t_radicand  remainder;
        t_radicand  root;
        t_radicand  step_bit;
        mag_a     = a[CW-1] ? t_component'(~a + 1'b1) : a;
        mag_b     = b[CW-1] ? t_component'(~b + 1'b1) : b;
        radicand  = t_radicand'(mag_a) * t_radicand'(mag_a)
                  + t_radicand'(mag_b) * t_radicand'(mag_b);
        remainder = radicand;
        root      = '0;
        step_bit  = t_radicand'(1) << (2*CW - 2);
        while (step_bit > radicand)
            step_bit = step_bit >> 2;
        while (step_bit != 0) begin
            if (remainder >= root + step_bit) begin
                remainder = remainder - (root + step_bit);
                root      = (root >> 1) + step_bit;
            end else begin
                root = root >> 1;
            end
            step_bit = step_bit >> 2;
        end
        return t_magnitude'(root);
    endfunction

    // Gap length for either channel: mostly none, often short, rarely long.
    function automatic int idle_length();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            return 0;
        else if (pick < 90)
            return $urandom_range(1, 3);
        else if (pick < 98)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    // Random component, weighted toward the corners of the range.
    function automatic t_component random_leg();
        int pick;
        int offset;
        pick   = $urandom_range(0, 99);
        offset = $urandom_range(0, 15);
        if (pick < 45)
            return t_component'($urandom);
        else if (pick < 60)
            return $urandom_range(0, 1) ? t_component'(32767 - offset)
                                        : t_component'(-32768 + offset);
        else if (pick < 80)
            return t_component'(int'($urandom_range(0, 128)) - 64);
        else if (pick < 90)
            return '0;
        else
            return $urandom_range(0, 1) ? t_component'(1 << $urandom_range(0, CW-2))
                                        : t_component'(-(1 << $urandom_range(0, CW-2)));
    endfunction

    // Offers one request after an optional gap and records its expected
    // magnitude once it is accepted. Returns at the following falling edge.
    task automatic offer_vector(input t_component a, input t_component b,
                                input bit has_value, input t_magnitude value,
                                input int gap);
        t_pending_magnitude entry;
        if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_valid <= 1'b1;
        leg_a     <= a;
        leg_b     <= b;
        do @(posedge clk); while (req_ready !== 1'b1);
        entry.leg_a     = a;
        entry.leg_b     = b;
        entry.magnitude = has_value ? value : vector_length_floor(a, b);
        magnitude_q.push_back(entry);
        @(negedge clk);
    endtask

    // Result sink: random stalls, quiet stretches, and the long hold-off that
    // lets the pipeline and queue fill until the request side stalls.
    initial begin : result_sink
        int stall;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever begin
            if (hold_off_req) begin
                res_ready  <= 1'b0;
                hold_active = 1'b1;
                repeat (HOLD_OFF_CYCLES) @(negedge clk);
                hold_off_req = 1'b0;
                hold_active  = 1'b0;
            end else begin
                stall = no_idle ? 0 : idle_length();
                if (stall == 0) begin
                    res_ready <= 1'b1;
                    @(negedge clk);
                end else begin
                    res_ready <= 1'b0;
                    repeat (stall) @(negedge clk);
                end
            end
        end
    end

    // In-order check of every accepted result against the oldest expectation.
    always @(posedge clk) begin
        t_pending_magnitude entry;
        if (rst_n && res_valid && res_ready) begin
            if (magnitude_q.size() == 0) begin
                $display("%0t: unexpected magnitude %0d with no request pending",
                         $time, magnitude);
                error_count++;
            end else begin
                entry = magnitude_q.pop_front();
                if (magnitude !== entry.magnitude) begin
                    $display("%0t: magnitude for legs %0d, %0d: expected %0d, actual %0d",
                             $time, $signed(entry.leg_a), $signed(entry.leg_b),
                             entry.magnitude, magnitude);
                    error_count++;
                end
            end
        end
    end

    // Ends the run if neither channel moves for too long.
    always @(posedge clk) begin
        if ((req_valid && req_ready === 1'b1) || (res_valid === 1'b1 && res_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, idle_cycles);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin : stimulus
        // Corners of the component range, exact squares and the unit diagonal carry typed-in
        // magnitudes; the remaining rows rely on the predictor.
        directed_rows = '{
            '{t_component'(0),      t_component'(0),      1'b1, t_magnitude'(0)},
            '{t_component'(1),      t_component'(0),      1'b1, t_magnitude'(1)},
            '{t_component'(0),      t_component'(-1),     1'b1, t_magnitude'(1)},
            '{t_component'(-1),     t_component'(-1),     1'b1, t_magnitude'(1)},
            '{t_component'(3),      t_component'(4),      1'b1, t_magnitude'(5)},
            '{t_component'(-3),     t_component'(4),      1'b1, t_magnitude'(5)},
            '{t_component'(5),      t_component'(-12),    1'b1, t_magnitude'(13)},
            '{t_component'(32767),  t_component'(0),      1'b1, t_magnitude'(32767)},
            '{t_component'(0),      t_component'(32767),  1'b1, t_magnitude'(32767)},
            '{t_component'(-32768), t_component'(0),      1'b1, t_magnitude'(32768)},
            '{t_component'(0),      t_component'(-32768), 1'b1, t_magnitude'(32768)},
            '{t_component'(32767),  t_component'(32767),  1'b1, t_magnitude'(46339)},
            '{t_component'(-32768), t_component'(-32768), 1'b1, t_magnitude'(46340)},
            '{t_component'(-32768), t_component'(32767),  1'b1, t_magnitude'(46340)},
            '{t_component'(32767),  t_component'(-32768), 1'b1, t_magnitude'(46340)},
            '{t_component'(2),      t_component'(3),      1'b0, t_magnitude'(0)},
            '{t_component'(-255),   t_component'(256),    1'b0, t_magnitude'(0)},
            '{t_component'('h5555), t_component'('hAAAA), 1'b0, t_magnitude'(0)},
            '{t_component'(32767),  t_component'(1),      1'b0, t_magnitude'(0)},
            '{t_component'(-32767), t_component'(-32767), 1'b0, t_magnitude'(0)},
            '{t_component'(181),    t_component'(181),    1'b0, t_magnitude'(0)},
            '{t_component'(1000),   t_component'(-1000),  1'b0, t_magnitude'(0)}
        };

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int row = 0; row < NUM_DIRECTED; row++)
            offer_vector(directed_rows[row].leg_a, directed_rows[row].leg_b,
                         directed_rows[row].has_value, directed_rows[row].magnitude,
                         idle_length());

        // Long output stall: wait until the sink has stopped, then offer
        // back-to-back requests so the block fills up and refuses input.
        req_valid   <= 1'b0;
        hold_off_req = 1'b1;
        @(negedge clk);
        while (!hold_active)
            @(negedge clk);
        for (int item = 0; item < BURST_ITEMS; item++)
            offer_vector(random_leg(), random_leg(), 1'b0, '0, 0);

        // Random requests in blocks; every fifth block runs without gaps.
        for (int item = 0; item < RANDOM_ITEMS; item++) begin
            if (item % BLOCK_ITEMS == 0)
                no_idle = ((item / BLOCK_ITEMS) % 5 == 2);
            offer_vector(random_leg(), random_leg(), 1'b0, '0,
                         no_idle ? 0 : idle_length());
        end
        req_valid <= 1'b0;
        no_idle    = 1'b0;

        while (magnitude_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
